FILE: src/ntvc_pkg.sv
// Shared types and constants for the view-cone nearest-target block.
package ntvc_pkg;

    localparam int ID_BITS   = 10;
    localparam int COORD_W   = 32;
    localparam int MAG_W     = 32;
    localparam int DIST_W    = 33;
    localparam int SUM_W     = 66;
    localparam int WIDE_W    = 2 * SUM_W + 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [SUM_W-1:0] COS_DEN_SQ = SUM_W'(2500);
    localparam logic [SUM_W-1:0] COS_NUM_SQ = SUM_W'(2401);

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd6;

    typedef struct packed {
        logic [ID_BITS-1:0]        entity_id;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      has_shape;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic [ID_BITS-1:0] nearest_id;
        logic [DIST_W-1:0]  nearest_distance;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic [DIST_W-1:0]         max_distance;
    } cfg_t;

    typedef struct packed {
        logic [ID_BITS-1:0]       entity_id;
        logic                     has_shape;
        logic                     last;
        logic [2:0]               v_neg;
        logic [2:0][MAG_W-1:0]    v_mag;
    } job_t;

endpackage

FILE: src/ntvc_queue.sv
// Two-entry job queue between front and back.
module ntvc_queue
    import ntvc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_job = mem[rd_ptr_reg];
    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);

endmodule

FILE: src/ntvc_front.sv
// Front end: takes items, forms origin-to-entity vector as sign and magnitude.
module ntvc_front
    import ntvc_pkg::*;
(
    input  logic     in_valid,
    input  in_item_t in_data,
    input  cfg_t     cfg,
    input  logic     q_full,
    output logic     in_stall,
    output logic     push,
    output job_t     job
);

    logic signed [COORD_W:0] v [3];
    logic [COORD_W:0]        m [3];

    always_comb
    begin
        v[0] = {in_data.pos_x[COORD_W-1], in_data.pos_x}
             - {cfg.origin_x[COORD_W-1], cfg.origin_x};
        v[1] = {in_data.pos_y[COORD_W-1], in_data.pos_y}
             - {cfg.origin_y[COORD_W-1], cfg.origin_y};
        v[2] = {in_data.pos_z[COORD_W-1], in_data.pos_z}
             - {cfg.origin_z[COORD_W-1], cfg.origin_z};
        job.entity_id = in_data.entity_id;
        job.has_shape = in_data.has_shape;
        job.last      = in_data.last;
        for (int i = 0; i < 3; i++)
        begin
            m[i]          = v[i][COORD_W] ? (~v[i] + 1'b1) : v[i];
            job.v_neg[i]  = v[i][COORD_W];
            job.v_mag[i]  = m[i][MAG_W-1:0];
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

FILE: src/ntvc_back.sv
// Back end: cone test, distance square root, running minimum and result register.
module ntvc_back
    import ntvc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  job_t      q_job,
    input  cfg_t      cfg,
    input  logic      out_stall,
    output logic      pop,
    output logic      out_valid,
    output out_item_t out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_ACC, S_CMP, S_MUL_TT, S_MUL_L, S_MUL_VD, S_MUL_R,
        S_SQRT, S_FINISH
    } state_t;

    localparam logic [1:0] KIND_VD = 2'd0;
    localparam logic [1:0] KIND_VV = 2'd1;
    localparam logic [1:0] KIND_DD = 2'd2;
    localparam logic [SUM_W-1:0] SQRT_ONE = {2'b01, {(SUM_W-2){1'b0}}};

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;
    logic              run_start_reg, run_start_next;
    logic              found_reg, found_next;
    logic [ID_BITS-1:0] best_id_reg, best_id_next;
    logic [DIST_W-1:0] best_reg, best_next;

    job_t              job_reg, job_next;
    logic [1:0]        axis_reg, axis_next;
    logic [1:0]        kind_reg, kind_next;
    logic [2*MAG_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]  pos_reg, pos_next, neg_reg, neg_next;
    logic [SUM_W-1:0]  vv_reg, vv_next, dd_reg, dd_next;
    logic [WIDE_W-1:0] mul_a_reg, mul_a_next, acc_reg, acc_next;
    logic [SUM_W-1:0]  mul_b_reg, mul_b_next;
    logic [WIDE_W-1:0] lhs_reg, lhs_next;
    logic [SUM_W-1:0]  op_reg, op_next, one_reg, one_next;
    logic [SUM_W:0]    res_reg, res_next;

    logic [MAG_W-1:0]  md [3];
    logic [2:0]        dneg;
    logic [MAG_W-1:0]  opa, opb;
    logic [SUM_W-1:0]  t_diff;
    logic [SUM_W:0]    trial;
    logic              out_free;

    always_comb
    begin
        dneg = {cfg.dir_z[COORD_W-1], cfg.dir_y[COORD_W-1], cfg.dir_x[COORD_W-1]};
        md[0] = dneg[0] ? (~cfg.dir_x + 1'b1) : cfg.dir_x;
        md[1] = dneg[1] ? (~cfg.dir_y + 1'b1) : cfg.dir_y;
        md[2] = dneg[2] ? (~cfg.dir_z + 1'b1) : cfg.dir_z;
        opa = (kind_reg == KIND_DD) ? md[axis_reg] : job_reg.v_mag[axis_reg];
        opb = (kind_reg == KIND_VV) ? job_reg.v_mag[axis_reg] : md[axis_reg];
        t_diff = pos_reg - neg_reg;
        trial = res_reg + {1'b0, one_reg};
        out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        run_start_next = run_start_reg;
        found_next     = found_reg;
        best_id_next   = best_id_reg;
        best_next      = best_reg;
        job_next       = job_reg;
        axis_next      = axis_reg;
        kind_next      = kind_reg;
        prod_next      = prod_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        vv_next        = vv_reg;
        dd_next        = dd_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        acc_next       = acc_reg;
        lhs_next       = lhs_reg;
        op_next        = op_reg;
        one_next       = one_reg;
        res_next       = res_reg;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    job_next  = q_job;
                    axis_next = 2'd0;
                    kind_next = KIND_VD;
                    pos_next  = '0;
                    neg_next  = '0;
                    vv_next   = '0;
                    dd_next   = '0;
                    if (run_start_reg)
                    begin
                        best_next      = cfg.max_distance;
                        best_id_next   = '0;
                        found_next     = 1'b0;
                        run_start_next = 1'b0;
                    end
                    state_next = q_job.has_shape ? S_PROD : S_FINISH;
                end
            end
            S_PROD:
            begin
                prod_next  = opa * opb;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                unique case (kind_reg)
                    KIND_VD:
                    begin
                        if (job_reg.v_neg[axis_reg] ^ dneg[axis_reg])
                        begin
                            neg_next = neg_reg + SUM_W'(prod_reg);
                        end
                        else
                        begin
                            pos_next = pos_reg + SUM_W'(prod_reg);
                        end
                    end
                    KIND_VV: vv_next = vv_reg + SUM_W'(prod_reg);
                    default: dd_next = dd_reg + SUM_W'(prod_reg);
                endcase
                if (kind_reg == KIND_DD)
                begin
                    kind_next  = KIND_VD;
                    axis_next  = axis_reg + 2'd1;
                    state_next = (axis_reg == 2'd2) ? S_CMP : S_PROD;
                end
                else
                begin
                    kind_next  = kind_reg + 2'd1;
                    state_next = S_PROD;
                end
            end
            S_CMP:
            begin
                mul_a_next = WIDE_W'(t_diff);
                mul_b_next = t_diff;
                acc_next   = '0;
                state_next = (pos_reg > neg_reg) ? S_MUL_TT : S_FINISH;
            end
            S_MUL_TT, S_MUL_L, S_MUL_VD, S_MUL_R:
            begin
                if (mul_b_reg == '0)
                begin
                    acc_next = '0;
                    unique case (state_reg)
                        S_MUL_TT:
                        begin
                            mul_a_next = acc_reg;
                            mul_b_next = COS_DEN_SQ;
                            state_next = S_MUL_L;
                        end
                        S_MUL_L:
                        begin
                            lhs_next   = acc_reg;
                            mul_a_next = WIDE_W'(vv_reg);
                            mul_b_next = dd_reg;
                            state_next = S_MUL_VD;
                        end
                        S_MUL_VD:
                        begin
                            mul_a_next = acc_reg;
                            mul_b_next = COS_NUM_SQ;
                            state_next = S_MUL_R;
                        end
                        default:
                        begin
                            op_next    = vv_reg;
                            res_next   = '0;
                            one_next   = SQRT_ONE;
                            state_next = (lhs_reg > acc_reg) ? S_SQRT : S_FINISH;
                        end
                    endcase
                end
                else
                begin
                    if (mul_b_reg[0])
                    begin
                        acc_next = acc_reg + mul_a_reg;
                    end
                    mul_a_next = {mul_a_reg[WIDE_W-2:0], 1'b0};
                    mul_b_next = {1'b0, mul_b_reg[SUM_W-1:1]};
                end
            end
            S_SQRT:
            begin
                if (one_reg == '0)
                begin
                    if (res_reg[DIST_W-1:0] < best_reg)
                    begin
                        best_next    = res_reg[DIST_W-1:0];
                        best_id_next = job_reg.entity_id;
                        found_next   = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    if ({1'b0, op_reg} >= trial)
                    begin
                        op_next  = op_reg - trial[SUM_W-1:0];
                        res_next = {1'b0, res_reg[SUM_W:1]} + {1'b0, one_reg};
                    end
                    else
                    begin
                        res_next = {1'b0, res_reg[SUM_W:1]};
                    end
                    one_next = {2'b00, one_reg[SUM_W-1:2]};
                end
            end
            S_FINISH:
            begin
                if (!job_reg.last)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next                 = 1'b1;
                    out_data_next.hit              = found_reg;
                    out_data_next.nearest_id       = best_id_reg;
                    out_data_next.nearest_distance = best_reg;
                    run_start_next                 = 1'b1;
                    state_next                     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            run_start_reg <= 1'b1;
            found_reg     <= 1'b0;
            best_id_reg   <= '0;
            best_reg      <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            run_start_reg <= run_start_next;
            found_reg     <= found_next;
            best_id_reg   <= best_id_next;
            best_reg      <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        axis_reg  <= axis_next;
        kind_reg  <= kind_next;
        prod_reg  <= prod_next;
        pos_reg   <= pos_next;
        neg_reg   <= neg_next;
        vv_reg    <= vv_next;
        dd_reg    <= dd_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        acc_reg   <= acc_next;
        lhs_reg   <= lhs_next;
        op_reg    <= op_next;
        one_reg   <= one_next;
        res_reg   <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/nearest_target_in_view_cone.sv
// Top level of the view-cone nearest-target block.
//
// Channels: in_valid/in_stall/in_data carries entity items; out_valid/
// out_stall/out_data carries one result per query, on the item marked last.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes origin, direction and
// maximum distance; cfg_ready is always high. Write only while idle.
// The front converts each item to a sign-magnitude vector and places it in a
// two-entry queue, so up to two items are taken while the back is busy.
// Per item the back uses its shared 32x32 multiplier, the bit-serial wide
// multiplier and the two-bits-a-step square root. An item with no shape goes
// straight to finish; the cone test fails early when the dot product is not
// positive; else the wide products run, then the square root if the cone holds.
// The back takes a new item only once it has finished the last one.
// Reset empties the queue, restores register reset values and starts a new
// query. When out_stall holds a result, the back waits at the next last item
// until the result register frees; items keep queueing until it is full.
module nearest_target_in_view_cone
    import ntvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIST_W-1:0]    cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_pop, q_full, q_empty;
    job_t push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: cfg_next.origin_x     = cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y: cfg_next.origin_y     = cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Z: cfg_next.origin_z     = cfg_data[COORD_W-1:0];
                CFG_DIR_X:    cfg_next.dir_x        = cfg_data[COORD_W-1:0];
                CFG_DIR_Y:    cfg_next.dir_y        = cfg_data[COORD_W-1:0];
                CFG_DIR_Z:    cfg_next.dir_z        = cfg_data[COORD_W-1:0];
                CFG_MAX_DIST: cfg_next.max_distance = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg              <= '0;
            cfg_reg.dir_z        <= COORD_W'(65536);
            cfg_reg.max_distance <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ntvc_front u_front (
        .in_valid (in_valid),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (q_push),
        .job      (push_job)
    );

    ntvc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    ntvc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .cfg       (cfg_reg),
        .out_stall (out_stall),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.nearest_id == '0)
        else $error("miss result carries an id");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> out_data.nearest_distance != '1)
        else $error("hit distance not below bound");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

FILE: tb/sv/nearest_target_in_view_cone_tb.sv
// Self-checking testbench for the view-cone nearest-target block.
module nearest_target_in_view_cone_tb;
    import ntvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DIST_W-1:0]    DIST_ALL   = {DIST_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIST_W-1:0]    cfg_data = '0;

    nearest_target_in_view_cone uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    in_item_t  pending_items[$];
    out_item_t awaited_results[$];
    cfg_t      ray_cfg;
    logic [DIST_W-1:0]  best_dist;
    logic [ID_BITS-1:0] best_id;
    logic               found;
    logic               run_start;
    logic               in_taken = 1'b0;
    int                 send_idle = 0;
    int                 recv_idle = 0;
    int                 errors = 0;

    function automatic logic [DIST_W-1:0] isqrt(logic [67:0] s);
        logic [DIST_W-1:0] res;
        logic [DIST_W-1:0] cand;
        res = '0;
        for (int b = DIST_W - 1; b >= 0; b--)
        begin
            cand = res | (DIST_W'(1) << b);
            if (68'(cand) * 68'(cand) <= s)
                res = cand;
        end
        return res;
    endfunction

    // Updates the running nearest target; returns 1 when a result is due.
    function automatic logic track_nearest(in_item_t it, output out_item_t res);
        logic signed [67:0] v[3];
        logic signed [67:0] d[3];
        logic signed [67:0] dot;
        logic [67:0]        vv;
        logic [67:0]        dd;
        logic [159:0]       lhs;
        logic [159:0]       rhs;
        logic [DIST_W-1:0]  near_dist;
        if (run_start)
        begin
            best_dist = ray_cfg.max_distance;
            best_id = '0;
            found = 1'b0;
            run_start = 1'b0;
        end
        if (it.has_shape)
        begin
            v[0] = 68'(it.pos_x) - 68'(ray_cfg.origin_x);
            v[1] = 68'(it.pos_y) - 68'(ray_cfg.origin_y);
            v[2] = 68'(it.pos_z) - 68'(ray_cfg.origin_z);
            d[0] = 68'(ray_cfg.dir_x);
            d[1] = 68'(ray_cfg.dir_y);
            d[2] = 68'(ray_cfg.dir_z);
            dot = '0;
            vv = '0;
            dd = '0;
            for (int i = 0; i < 3; i++)
            begin
                dot += v[i] * d[i];
                vv += 68'(v[i] * v[i]);
                dd += 68'(d[i] * d[i]);
            end
            if (dot > 0)
            begin
                lhs = 160'(dot) * 160'(dot) * 160'(2500);
                rhs = 160'(vv) * 160'(dd) * 160'(2401);
                if (lhs > rhs)
                begin
                    near_dist = isqrt(vv);
                    if (near_dist < best_dist)
                    begin
                        best_dist = near_dist;
                        best_id = it.entity_id;
                        found = 1'b1;
                    end
                end
            end
        end
        res.hit = found;
        res.nearest_id = found ? best_id : '0;
        res.nearest_distance = best_dist;
        if (it.last)
            run_start = 1'b1;
        return it.last;
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_idle);
            if (!in_valid || in_taken)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t res;
        out_item_t want;
        in_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            if (track_nearest(in_data, res))
                awaited_results.push_back(res);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", out_data);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_data.hit !== want.hit || out_data.nearest_id !== want.nearest_id
                    || out_data.nearest_distance !== want.nearest_distance)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || awaited_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ORIGIN_X: ray_cfg.origin_x = val[31:0];
            CFG_ORIGIN_Y: ray_cfg.origin_y = val[31:0];
            CFG_ORIGIN_Z: ray_cfg.origin_z = val[31:0];
            CFG_DIR_X:    ray_cfg.dir_x = val[31:0];
            CFG_DIR_Y:    ray_cfg.dir_y = val[31:0];
            CFG_DIR_Z:    ray_cfg.dir_z = val[31:0];
            CFG_MAX_DIST: ray_cfg.max_distance = val;
            default: ;
        endcase
    endtask

    task automatic set_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                           logic signed [31:0] oz, logic signed [31:0] dx,
                           logic signed [31:0] dy, logic signed [31:0] dz,
                           logic [DIST_W-1:0] md);
        write_reg(CFG_ORIGIN_X, DIST_W'(ox));
        write_reg(CFG_ORIGIN_Y, DIST_W'(oy));
        write_reg(CFG_ORIGIN_Z, DIST_W'(oz));
        write_reg(CFG_DIR_X, DIST_W'(dx));
        write_reg(CFG_DIR_Y, DIST_W'(dy));
        write_reg(CFG_DIR_Z, DIST_W'(dz));
        write_reg(CFG_MAX_DIST, md);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_item(int id, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic shape, logic lst);
        in_item_t it;
        it.entity_id = id[ID_BITS-1:0];
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.has_shape = shape;
        it.last = lst;
        pending_items.push_back(it);
    endtask

    // Queries of random length; most items lie near the ray, some are noise.
    task automatic push_queries(int count);
        in_item_t it;
        in_item_t prev;
        int       len;
        int       k;
        longint   t;
        k = 0;
        prev = '0;
        while (k < count)
        begin
            len = $urandom_range(8, 1);
            for (int j = 0; j < len; j++)
            begin
                it.entity_id = ID_BITS'($urandom);
                it.has_shape = ($urandom_range(9) != 0);
                it.last = (j == len - 1);
                case ($urandom_range(9))
                    0, 1:
                    begin
                        it.pos_x = $urandom;
                        it.pos_y = $urandom;
                        it.pos_z = $urandom;
                    end
                    2:
                    begin
                        it.pos_x = prev.pos_x;
                        it.pos_y = prev.pos_y;
                        it.pos_z = prev.pos_z;
                    end
                    default:
                    begin
                        t = $urandom_range(4, 1);
                        it.pos_x = 32'(longint'(ray_cfg.origin_x)
                                   + t * longint'(ray_cfg.dir_x) + $urandom_range(255));
                        it.pos_y = 32'(longint'(ray_cfg.origin_y)
                                   + t * longint'(ray_cfg.dir_y) + $urandom_range(255));
                        it.pos_z = 32'(longint'(ray_cfg.origin_z)
                                   + t * longint'(ray_cfg.dir_z) + $urandom_range(255));
                    end
                endcase
                pending_items.push_back(it);
                prev = it;
            end
            k += len;
        end
    endtask

    function automatic logic signed [31:0] rand_dir();
        return ($urandom_range(5) == 0) ? 32'sd0
               : 32'($signed($urandom_range(2097152)) - 1048576);
    endfunction

    initial
    begin
        logic [DIST_W-1:0] md;
        ray_cfg = '{origin_x: 0, origin_y: 0, origin_z: 0, dir_x: 0, dir_y: 0,
                    dir_z: 65536, max_distance: DIST_ALL};
        best_dist = DIST_ALL;
        best_id = '0;
        found = 1'b0;
        run_start = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset ray along +z: hit, tie, zero vector, skipped last, extremes.
        push_item(5, 0, 0, 32'h0002_0000, 1, 0);
        push_item(9, 0, 0, 32'h0002_0000, 1, 0);
        push_item(1023, 0, 0, 0, 1, 0);
        push_item(3, 0, 0, 32'h0003_0000, 0, 1);
        push_item(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1);
        push_item(1023, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1);
        push_item(7, 0, 0, 32'h7FFF_FFFF, 1, 0);
        push_item(8, 0, 0, 32'h8000_0000, 1, 1);
        push_item(2, 0, 0, 0, 0, 1);
        wait_idle();

        set_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000, DIST_ALL);
        push_item(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
        push_item(2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1);
        push_item(3, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1);
        wait_idle();

        // Distance at the bound is rejected, below it kept.
        set_ray(0, 0, 0, 65536, 0, 0, DIST_W'(32'h0002_0000));
        push_item(4, 32'h0002_0000, 0, 0, 1, 0);
        push_item(6, 32'h0001_FFFF, 0, 0, 1, 1);
        push_item(4, 32'h0001_0000, 0, 0, 1, 1);
        wait_idle();
        set_ray(0, 0, 0, 65536, 0, 0, '0);
        push_item(1, 32'h0000_0001, 0, 0, 1, 1);
        wait_idle();
        write_reg(CFG_UNUSED, DIST_W'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph < 4)
            begin
                send_idle = 37;
                recv_idle = 46;
            end
            else if (ph < 8)
            begin
                send_idle = 46;
                recv_idle = 37;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case ($urandom_range(3))
                0: md = DIST_ALL;
                1: md = {$urandom, $urandom} & DIST_ALL;
                default: md = DIST_W'($urandom_range(32'h0080_0000));
            endcase
            set_ray(32'($signed($urandom_range(33554432)) - 16777216),
                    32'($signed($urandom_range(33554432)) - 16777216),
                    32'($signed($urandom_range(33554432)) - 16777216),
                    rand_dir(), rand_dir(), 32'sd65536 + rand_dir(), md);
            push_queries(34);
            wait_idle();
        end

        wait_idle();
        if (errors == 0)
            $display("nearest_target_in_view_cone verification clean");
        else
            $display("nearest_target_in_view_cone verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("nearest_target_in_view_cone verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/ntvc_pkg.sv
src/ntvc_queue.sv
src/ntvc_front.sv
src/ntvc_back.sv
src/nearest_target_in_view_cone.sv
tb/sv/nearest_target_in_view_cone_tb.sv
